>>> hdl/date_time_setting_editor_unit_defines.svh
// Assertion macros for the date/time setting editor.
`ifndef DATE_TIME_SETTING_EDITOR_UNIT_DEFINES_SVH
`define DATE_TIME_SETTING_EDITOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is asserted.
`define DTSE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dtse check failed");
// Clocked check that also holds during reset.
`define DTSE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) else $error("dtse check failed");
`else
`define DTSE_ASSERT(name, clk, rst_n, prop)
`define DTSE_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> hdl/dtse_pkg.sv
// Shared types, codes and a helper function of the date/time setting editor.
package dtse_pkg;

  typedef enum logic [1:0] {
    BTN_UP    = 2'd0,
    BTN_DOWN  = 2'd1,
    BTN_ENTER = 2'd2,
    BTN_BACK  = 2'd3
  } btn_e;

  // Request kinds carried on tuser
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_BUTTON = 1'b1;

  // Edit targets
  localparam logic TGT_DATE = 1'b0;
  localparam logic TGT_TIME = 1'b1;

  // Date fields
  localparam logic [1:0] FLD_DAY     = 2'd0;
  localparam logic [1:0] FLD_MONTH   = 2'd1;
  localparam logic [1:0] FLD_YEAR    = 2'd2;
  localparam logic [1:0] FLD_WEEKDAY = 2'd3;
  // Time fields
  localparam logic [1:0] FLD_HOURS   = 2'd0;
  localparam logic [1:0] FLD_MINUTES = 2'd1;
  localparam logic [1:0] FLD_AMPM    = 2'd2;

  // Register index (word address bit)
  localparam logic REG_TWELVE_HOUR = 1'b0;

  localparam logic [6:0] YEAR_MIN    = 7'd26;
  localparam logic [6:0] YEAR_MAX    = 7'd99;
  localparam logic [3:0] MONTH_MAX   = 4'd12;
  localparam logic [2:0] WEEKDAY_MAX = 3'd7;
  localparam logic [5:0] MINUTE_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [4:0] HALF_DAY    = 5'd12;
  localparam logic [4:0] HALF_LAST   = 5'd11;

  typedef struct packed {
    logic       active;
    logic       is_time;
    logic [1:0] cursor;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } dtse_state_t;

  typedef struct packed {
    logic       req_type;
    logic       edit_target;
    btn_e       button;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } dtse_req_t;

  typedef struct packed {
    logic commit;
    logic cancelled;
  } dtse_flags_t;

  // Days in a month; leap rule taken on the two-digit year (0 is leap, 100 is not).
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] len;
    len = 5'd31;
    case (m)
      4'd2: begin
        len = ((y[1:0] == 2'd0) && (y != 7'd100)) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

>>> hdl/dtse_step.sv
// Next-state and result flags for one editor request.
module dtse_step (
  input  dtse_pkg::dtse_state_t state_i,
  input  dtse_pkg::dtse_req_t   req_i,
  input  logic                  twelve_hour_i,
  output dtse_pkg::dtse_state_t state_o,
  output dtse_pkg::dtse_flags_t flags_o
);

  logic       up;
  logic [4:0] hmod;
  logic [4:0] hstep;
  logic [4:0] h12;
  logic [5:0] hsum;
  logic [4:0] hampm;
  logic [3:0] mnew;
  logic [6:0] ynew;
  logic [4:0] lim_day;
  logic [4:0] lim_mon;
  logic [4:0] lim_yr;
  logic [1:0] last;

  always_comb begin
    up = (req_i.button == dtse_pkg::BTN_UP);

    // 12-hour step within the current half-day; hours 24 and above land in PM
    if (state_i.hours < 5'd12) begin
      hmod = state_i.hours;
    end else if (state_i.hours < 5'd24) begin
      hmod = state_i.hours - 5'd12;
    end else begin
      hmod = state_i.hours - 5'd24;
    end
    if (up) begin
      hstep = (hmod == dtse_pkg::HALF_LAST) ? 5'd0 : hmod + 5'd1;
    end else begin
      hstep = (hmod == 5'd0) ? dtse_pkg::HALF_LAST : hmod - 5'd1;
    end
    h12 = ((state_i.hours >= dtse_pkg::HALF_DAY) ? dtse_pkg::HALF_DAY : 5'd0) + hstep;

    // AM/PM flip: add twelve modulo a day
    hsum  = {1'b0, state_i.hours} + 6'd12;
    hampm = (hsum >= 6'd24) ? 5'(hsum - 6'd24) : hsum[4:0];

    if (up) begin
      mnew = (state_i.month < dtse_pkg::MONTH_MAX) ? state_i.month + 4'd1 : state_i.month;
      ynew = (state_i.year < dtse_pkg::YEAR_MAX) ? state_i.year + 7'd1 : state_i.year;
    end else begin
      mnew = (state_i.month > 4'd1) ? state_i.month - 4'd1 : state_i.month;
      ynew = (state_i.year > dtse_pkg::YEAR_MIN) ? state_i.year - 7'd1 : state_i.year;
    end
    lim_day = dtse_pkg::month_len(state_i.month, state_i.year);
    lim_mon = dtse_pkg::month_len(mnew, state_i.year);
    lim_yr  = dtse_pkg::month_len(state_i.month, ynew);

    if (state_i.is_time) begin
      last = twelve_hour_i ? dtse_pkg::FLD_AMPM : dtse_pkg::FLD_MINUTES;
    end else begin
      last = dtse_pkg::FLD_WEEKDAY;
    end
  end

  always_comb begin
    state_o = state_i;
    flags_o = '0;
    if (req_i.req_type == dtse_pkg::REQ_LOAD) begin
      state_o.active  = 1'b1;
      state_o.is_time = req_i.edit_target;
      state_o.cursor  = 2'd0;
      state_o.hours   = req_i.hours;
      state_o.minutes = req_i.minutes;
      state_o.weekday = req_i.weekday;
      state_o.day     = req_i.day;
      state_o.month   = req_i.month;
      state_o.year    = req_i.year;
    end else if (state_i.active) begin
      case (req_i.button)
        dtse_pkg::BTN_UP, dtse_pkg::BTN_DOWN: begin
          if (state_i.is_time == dtse_pkg::TGT_TIME) begin
            if (state_i.cursor == dtse_pkg::FLD_MINUTES) begin
              if (up) begin
                state_o.minutes = (state_i.minutes < dtse_pkg::MINUTE_MAX) ?
                                  state_i.minutes + 6'd1 : 6'd0;
              end else begin
                state_o.minutes = (state_i.minutes > 6'd0) ?
                                  state_i.minutes - 6'd1 : dtse_pkg::MINUTE_MAX;
              end
            end else if (twelve_hour_i) begin
              if (state_i.cursor == dtse_pkg::FLD_HOURS) begin
                state_o.hours = h12;
              end else if (state_i.cursor == dtse_pkg::FLD_AMPM) begin
                state_o.hours = hampm;
              end
            end else if (state_i.cursor == dtse_pkg::FLD_HOURS) begin
              if (up) begin
                state_o.hours = (state_i.hours < dtse_pkg::HOUR_MAX) ?
                                state_i.hours + 5'd1 : 5'd0;
              end else begin
                state_o.hours = (state_i.hours > 5'd0) ?
                                state_i.hours - 5'd1 : dtse_pkg::HOUR_MAX;
              end
            end
          end else begin
            case (state_i.cursor)
              dtse_pkg::FLD_DAY: begin
                if (up) begin
                  if (state_i.day < lim_day) state_o.day = state_i.day + 5'd1;
                end else if (state_i.day > 5'd1) begin
                  state_o.day = state_i.day - 5'd1;
                end
              end
              dtse_pkg::FLD_MONTH: begin
                state_o.month = mnew;
                if (state_i.day > lim_mon) state_o.day = lim_mon;
              end
              dtse_pkg::FLD_YEAR: begin
                state_o.year = ynew;
                if (state_i.day > lim_yr) state_o.day = lim_yr;
              end
              default: begin
                if (up) begin
                  if (state_i.weekday < dtse_pkg::WEEKDAY_MAX) begin
                    state_o.weekday = state_i.weekday + 3'd1;
                  end
                end else if (state_i.weekday > 3'd1) begin
                  state_o.weekday = state_i.weekday - 3'd1;
                end
              end
            endcase
          end
        end
        dtse_pkg::BTN_ENTER: begin
          if (state_i.cursor < last) begin
            state_o.cursor = state_i.cursor + 2'd1;
          end else begin
            state_o.cursor = 2'd0;
            state_o.active = 1'b0;
            flags_o.commit = 1'b1;
          end
        end
        default: begin
          if (state_i.cursor > 2'd0) begin
            state_o.cursor = state_i.cursor - 2'd1;
          end else begin
            state_o.active    = 1'b0;
            flags_o.cancelled = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

>>> hdl/date_time_setting_editor_unit.sv
// Top level of the date/time setting editor: stream ports, register port, state.
// An accepted request's result is registered and shown on the master side in the next cycle.
// Throughput: one request per cycle; the single output register is refilled in the
// same cycle it is drained, so s_axis_tready drops only while a result is stalled.
// Reset (rst_ni low, asynchronous): session closed, cursor 0, values 0/0/1/1/1/0,
// 24-hour mode, no result pending.
`include "date_time_setting_editor_unit_defines.svh"

module date_time_setting_editor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] edit_target, [2:1] button, [7:3] load_hours, [13:8] load_minutes,
  // [16:14] load_weekday, [21:17] load_day, [25:22] load_month,
  // [32:26] load_year, [39:33] zero
  input  logic [39:0] s_axis_tdata,
  // [0] req_type
  input  logic        s_axis_tuser,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] out_hours, [10:5] out_minutes, [13:11] out_weekday, [18:14] out_day,
  // [22:19] out_month, [29:23] out_year, [31:30] out_cursor, [32] commit,
  // [33] cancelled, [34] session_active, [39:35] zero
  output logic [39:0] m_axis_tdata,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dtse_pkg::dtse_state_t state_q, state_d;
  dtse_pkg::dtse_req_t   req;
  dtse_pkg::dtse_flags_t flags;
  logic                  twelve_hour_q;
  logic                  out_valid_q;
  logic [39:0]           out_data_q, out_data_d;
  logic                  in_fire;
  logic                  cfg_wr;

  // Register port: always ready, one register at word 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == dtse_pkg::REG_TWELVE_HOUR);
  assign prdata = (paddr[2] == dtse_pkg::REG_TWELVE_HOUR) ? {31'd0, twelve_hour_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      twelve_hour_q <= 1'b0;
    end else if (cfg_wr) begin
      twelve_hour_q <= pwdata[0];
    end
  end

  // Unpack the request
  assign req.req_type    = s_axis_tuser;
  assign req.edit_target = s_axis_tdata[0];
  assign req.button      = dtse_pkg::btn_e'(s_axis_tdata[2:1]);
  assign req.hours       = s_axis_tdata[7:3];
  assign req.minutes     = s_axis_tdata[13:8];
  assign req.weekday     = s_axis_tdata[16:14];
  assign req.day         = s_axis_tdata[21:17];
  assign req.month       = s_axis_tdata[25:22];
  assign req.year        = s_axis_tdata[32:26];

  // Accept whenever the output register is empty or being drained this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  dtse_step u_step (
    .state_i       (state_q),
    .req_i         (req),
    .twelve_hour_i (twelve_hour_q),
    .state_o       (state_d),
    .flags_o       (flags)
  );

  // Editor state: advance on every accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.active  <= 1'b0;
      state_q.is_time <= 1'b0;
      state_q.cursor  <= 2'd0;
      state_q.hours   <= 5'd0;
      state_q.minutes <= 6'd0;
      state_q.weekday <= 3'd1;
      state_q.day     <= 5'd1;
      state_q.month   <= 4'd1;
      state_q.year    <= 7'd0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Pack the result of this request
  assign out_data_d = {5'd0, state_d.active, flags.cancelled, flags.commit, state_d.cursor,
                       state_d.year, state_d.month, state_d.day, state_d.weekday,
                       state_d.minutes, state_d.hours};

  // Output register: load on accept, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A finished session never both commits and cancels
  `DTSE_ASSERT(a_commit_xor_cancel, clk_i, rst_ni, out_valid_q |-> !(out_data_q[32] && out_data_q[33]))
  // Commit or cancel leaves the session closed; commit also homes the cursor
  `DTSE_ASSERT(a_close_on_finish, clk_i, rst_ni, (out_valid_q && (out_data_q[32] || out_data_q[33])) |-> (!out_data_q[34] && (!out_data_q[32] || out_data_q[31:30] == 2'd0)))
  // Buttons outside a session leave all stored values untouched
  `DTSE_ASSERT(a_idle_button_ignored, clk_i, rst_ni, (in_fire && (s_axis_tuser == dtse_pkg::REQ_BUTTON) && !state_q.active) |=> $stable(state_q))

endmodule

>>> tb/sv/tb.sv
// Self-checking stream testbench for the date/time setting editor.
module tb;

  // Results are registered and each request yields one, so the only long quiet spell
  // in a good run is the deliberate output hold-off below.
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_REQS     = 155;
  localparam int NUM_PHASES     = 5;

  // Values, cursor and flags seen on the result stream after one request.
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [1:0] cursor;
    logic       commit;
    logic       cancelled;
    logic       active;
  } editor_view_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  date_time_setting_editor_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Requests waiting to be driven, and predicted results in request order.
  dtse_pkg::dtse_req_t pending_reqs[$];
  editor_view_t        editor_snapshots[$];

  // Shadow copy of the editor and of its mode register.
  dtse_pkg::dtse_state_t shadow;
  bit                    clock_12h;

  dtse_pkg::dtse_req_t offered_req;
  bit        req_taken = 1'b0;
  bit        steady_run = 1'b0;
  int        src_gap = 0;
  int        sink_gap = 0;
  int        hold_left = 0;
  int        hold_off_asked = 0;
  int        hold_off_served = 0;
  int        idle_cycles = 0;

  int reqs_queued = 0;
  int reqs_accepted = 0;
  int loads_accepted = 0;
  int results_checked = 0;
  int commits_seen = 0;
  int cancels_seen = 0;
  int mismatch_count = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Month length; the leap rule is applied to the two-digit year as stored,
  // so year 0 counts as leap. Any month outside 1..12 has 31 days.
  function automatic int month_days(input logic [3:0] m, input logic [6:0] y);
    int yr;
    yr = y;
    if (m == 4'd2) return (((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0)) ? 29 : 28;
    if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) return 30;
    return 31;
  endfunction

  function automatic void clamp_day();
    int lim;
    lim = month_days(shadow.month, shadow.year);
    if (shadow.day > lim) shadow.day = 5'(lim);
  endfunction

  // Date fields saturate at their bounds; month and year changes re-clamp the day.
  function automatic void step_date(input bit up);
    case (shadow.cursor)
      dtse_pkg::FLD_DAY: begin
        if (up) begin
          if (shadow.day < month_days(shadow.month, shadow.year))
            shadow.day = shadow.day + 5'd1;
        end else if (shadow.day > 5'd1) begin
          shadow.day = shadow.day - 5'd1;
        end
      end
      dtse_pkg::FLD_MONTH: begin
        if (up) begin
          if (shadow.month < dtse_pkg::MONTH_MAX) shadow.month = shadow.month + 4'd1;
        end else if (shadow.month > 4'd1) begin
          shadow.month = shadow.month - 4'd1;
        end
        clamp_day();
      end
      dtse_pkg::FLD_YEAR: begin
        if (up) begin
          if (shadow.year < dtse_pkg::YEAR_MAX) shadow.year = shadow.year + 7'd1;
        end else if (shadow.year > dtse_pkg::YEAR_MIN) begin
          shadow.year = shadow.year - 7'd1;
        end
        clamp_day();
      end
      default: begin
        if (up) begin
          if (shadow.weekday < dtse_pkg::WEEKDAY_MAX) shadow.weekday = shadow.weekday + 3'd1;
        end else if (shadow.weekday > 3'd1) begin
          shadow.weekday = shadow.weekday - 3'd1;
        end
      end
    endcase
  endfunction

  // Minutes and 24-hour hours wrap; 12-hour hours cycle inside their half-day,
  // and the AM/PM field moves the hour by twelve.
  function automatic void step_time(input bit up);
    int h;
    h = shadow.hours;
    if (shadow.cursor == dtse_pkg::FLD_MINUTES) begin
      if (up) begin
        shadow.minutes = (shadow.minutes < dtse_pkg::MINUTE_MAX) ?
                         shadow.minutes + 6'd1 : 6'd0;
      end else begin
        shadow.minutes = (shadow.minutes > 6'd0) ?
                         shadow.minutes - 6'd1 : dtse_pkg::MINUTE_MAX;
      end
    end else if (clock_12h) begin
      if (shadow.cursor == dtse_pkg::FLD_HOURS) begin
        h = up ? ((shadow.hours % 12) + 1) % 12 : ((shadow.hours % 12) + 11) % 12;
        shadow.hours = 5'(((shadow.hours >= dtse_pkg::HALF_DAY) ? 12 : 0) + h);
      end else if (shadow.cursor == dtse_pkg::FLD_AMPM) begin
        shadow.hours = 5'((h + 12) % 24);
      end
    end else if (shadow.cursor == dtse_pkg::FLD_HOURS) begin
      if (up) begin
        shadow.hours = (shadow.hours < dtse_pkg::HOUR_MAX) ? shadow.hours + 5'd1 : 5'd0;
      end else begin
        shadow.hours = (shadow.hours > 5'd0) ? shadow.hours - 5'd1 : dtse_pkg::HOUR_MAX;
      end
    end
  endfunction

  // Apply one accepted request to the shadow editor and store the result it causes.
  function automatic void advance_editor(input dtse_pkg::dtse_req_t rq);
    editor_view_t v;
    int           last_field;
    bit           done_ok;
    bit           quit;
    done_ok = 1'b0;
    quit    = 1'b0;
    if (rq.req_type == dtse_pkg::REQ_LOAD) begin
      shadow.active  = 1'b1;
      shadow.is_time = rq.edit_target;
      shadow.cursor  = 2'd0;
      shadow.hours   = rq.hours;
      shadow.minutes = rq.minutes;
      shadow.weekday = rq.weekday;
      shadow.day     = rq.day;
      shadow.month   = rq.month;
      shadow.year    = rq.year;
    end else if (shadow.active) begin
      last_field = shadow.is_time ? (clock_12h ? 2 : 1) : 3;
      case (rq.button)
        dtse_pkg::BTN_UP, dtse_pkg::BTN_DOWN: begin
          if (shadow.is_time) step_time(rq.button == dtse_pkg::BTN_UP);
          else step_date(rq.button == dtse_pkg::BTN_UP);
        end
        dtse_pkg::BTN_ENTER: begin
          if (shadow.cursor < last_field) begin
            shadow.cursor = shadow.cursor + 2'd1;
          end else begin
            shadow.cursor = 2'd0;
            shadow.active = 1'b0;
            done_ok = 1'b1;
          end
        end
        default: begin
          if (shadow.cursor > 2'd0) begin
            shadow.cursor = shadow.cursor - 2'd1;
          end else begin
            shadow.active = 1'b0;
            quit = 1'b1;
          end
        end
      endcase
    end
    v.hours     = shadow.hours;
    v.minutes   = shadow.minutes;
    v.weekday   = shadow.weekday;
    v.day       = shadow.day;
    v.month     = shadow.month;
    v.year      = shadow.year;
    v.cursor    = shadow.cursor;
    v.commit    = done_ok;
    v.cancelled = quit;
    v.active    = shadow.active;
    editor_snapshots.push_back(v);
    commits_seen += done_ok;
    cancels_seen += quit;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch on result %0d: %s", $time, results_checked, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string what, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", what, got, want));
  endtask

  task automatic check_result(input logic [39:0] word);
    editor_view_t want;
    if (editor_snapshots.size() == 0) begin
      report_mismatch($sformatf("result %h arrived with no request outstanding", word));
    end else begin
      want = editor_snapshots.pop_front();
      compare_field("hours", word[4:0], want.hours);
      compare_field("minutes", word[10:5], want.minutes);
      compare_field("weekday", word[13:11], want.weekday);
      compare_field("day", word[18:14], want.day);
      compare_field("month", word[22:19], want.month);
      compare_field("year", word[29:23], want.year);
      compare_field("cursor", word[31:30], want.cursor);
      compare_field("commit", word[32], want.commit);
      compare_field("cancelled", word[33], want.cancelled);
      compare_field("session_active", word[34], want.active);
      compare_field("padding", word[39:35], 0);
      results_checked++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request construction
  // ---------------------------------------------------------------------------

  function automatic dtse_pkg::btn_e pick_button();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return dtse_pkg::BTN_UP;
    if (r < 65) return dtse_pkg::BTN_DOWN;
    if (r < 90) return dtse_pkg::BTN_ENTER;
    return dtse_pkg::BTN_BACK;
  endfunction

  // Button press; the load fields and target ride along as random filler.
  function automatic dtse_pkg::dtse_req_t press_req(input dtse_pkg::btn_e b);
    dtse_pkg::dtse_req_t rq;
    rq.req_type    = dtse_pkg::REQ_BUTTON;
    rq.edit_target = 1'($urandom);
    rq.button      = b;
    rq.hours       = 5'($urandom);
    rq.minutes     = 6'($urandom);
    rq.weekday     = 3'($urandom);
    rq.day         = 5'($urandom);
    rq.month       = 4'($urandom);
    rq.year        = 7'($urandom);
    return rq;
  endfunction

  function automatic dtse_pkg::dtse_req_t load_req(input logic tgt, input int h, input int mi,
                                                   input int wd, input int d, input int mo,
                                                   input int y);
    dtse_pkg::dtse_req_t rq;
    rq = press_req(dtse_pkg::btn_e'($urandom_range(0, 3)));
    rq.req_type    = dtse_pkg::REQ_LOAD;
    rq.edit_target = tgt;
    rq.hours       = 5'(h);
    rq.minutes     = 6'(mi);
    rq.weekday     = 3'(wd);
    rq.day         = 5'(d);
    rq.month       = 4'(mo);
    rq.year        = 7'(y);
    return rq;
  endfunction

  // A well-formed load, or with wild set, any bit pattern in every field.
  function automatic dtse_pkg::dtse_req_t random_load(input bit wild);
    dtse_pkg::dtse_req_t rq;
    int                  mo;
    int                  y;
    rq = press_req(dtse_pkg::btn_e'($urandom_range(0, 3)));
    rq.req_type    = dtse_pkg::REQ_LOAD;
    rq.edit_target = 1'($urandom);
    if (!wild) begin
      mo = $urandom_range(1, 12);
      y  = $urandom_range(0, 99);
      rq.hours   = 5'($urandom_range(0, 23));
      rq.minutes = 6'($urandom_range(0, 59));
      rq.weekday = 3'($urandom_range(1, 7));
      rq.month   = 4'(mo);
      rq.year    = 7'(y);
      rq.day     = 5'($urandom_range(1, month_days(4'(mo), 7'(y))));
    end
    return rq;
  endfunction

  task automatic queue_req(input dtse_pkg::dtse_req_t rq);
    pending_reqs.push_back(rq);
    reqs_queued++;
  endtask

  // Mostly sessions (load, then a run of presses that often reaches commit or
  // cancel); now and then a few loose presses that may land outside a session.
  task automatic queue_random_sessions(input int target);
    int queued;
    int presses;
    queued = 0;
    while (queued < target) begin
      if ($urandom_range(0, 9) == 0) begin
        presses = $urandom_range(1, 3);
      end else begin
        queue_req(random_load($urandom_range(0, 9) == 0));
        queued++;
        presses = $urandom_range(1, 24);
      end
      repeat (presses) begin
        queue_req(press_req(pick_button()));
        queued++;
      end
    end
  endtask

  // Hold until every queued request has been taken and answered.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (reqs_accepted != reqs_queued || editor_snapshots.size() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle; the write lands on the
  // rising edge where the access phase meets pready. Call at a falling edge.
  task automatic set_clock_mode(input bit twelve);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {dtse_pkg::REG_TWELVE_HOUR, 2'b00};
    pwdata  <= {31'd0, twelve};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    clock_12h = twelve;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: advance to the next request once the current one is taken,
  // with random idle bursts between requests unless the run is in its steady tail.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (src_gap > 0 && !steady_run) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (!steady_run && pending_reqs.size() != 0 && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 17);
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        offered_req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= offered_req.req_type;
        s_axis_tdata  <= {7'd0, offered_req.year, offered_req.month, offered_req.day,
                          offered_req.weekday, offered_req.minutes, offered_req.hours,
                          offered_req.button, offered_req.edit_target};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, plus one long hold-off on request so the
  // output register fills and the block has to drop s_axis_tready.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_off_asked > hold_off_served) begin
      hold_off_served++;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0 && !steady_run) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (!steady_run && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results first, then predict for the request taken at the same
  // edge (its result is registered, so it cannot show up at that edge). Watchdog last.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        advance_editor(offered_req);
        reqs_accepted++;
        loads_accepted += (offered_req.req_type == dtse_pkg::REQ_LOAD);
      end
      req_taken <= s_axis_tvalid && s_axis_tready;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  idle_cycles, editor_snapshots.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    shadow = '{active: 1'b0, is_time: 1'b0, cursor: 2'd0, hours: 5'd0, minutes: 6'd0,
               weekday: 3'd1, day: 5'd1, month: 4'd1, year: 7'd0};
    clock_12h = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // 24-hour mode straight out of reset. A press with no session is ignored.
    queue_req(press_req(dtse_pkg::BTN_UP));
    // Date at its upper bounds: day, year and weekday saturate; February clamps to 28.
    queue_req(load_req(dtse_pkg::TGT_DATE, 0, 0, 7, 31, 1, 99));
    queue_req(press_req(dtse_pkg::BTN_UP));
    queue_req(press_req(dtse_pkg::BTN_ENTER));
    queue_req(press_req(dtse_pkg::BTN_UP));
    queue_req(press_req(dtse_pkg::BTN_ENTER));
    queue_req(press_req(dtse_pkg::BTN_UP));
    queue_req(press_req(dtse_pkg::BTN_ENTER));
    queue_req(press_req(dtse_pkg::BTN_UP));
    queue_req(press_req(dtse_pkg::BTN_ENTER));
    // Lower bounds: day 1 holds on down and month steps down from 3; back on field 0 cancels.
    queue_req(load_req(dtse_pkg::TGT_DATE, 0, 0, 1, 1, 3, 26));
    queue_req(press_req(dtse_pkg::BTN_DOWN));
    queue_req(press_req(dtse_pkg::BTN_ENTER));
    queue_req(press_req(dtse_pkg::BTN_DOWN));
    queue_req(press_req(dtse_pkg::BTN_BACK));
    queue_req(press_req(dtse_pkg::BTN_BACK));
    // Time wrap at 23:59, commit on the minutes field.
    queue_req(load_req(dtse_pkg::TGT_TIME, 23, 59, 1, 1, 1, 0));
    queue_req(press_req(dtse_pkg::BTN_UP));
    queue_req(press_req(dtse_pkg::BTN_ENTER));
    queue_req(press_req(dtse_pkg::BTN_UP));
    queue_req(press_req(dtse_pkg::BTN_ENTER));
    wait_idle();

    // 12-hour mode: out-of-range hour 31 lands in the PM half, minutes wrap down,
    // AM/PM flips; leave the session open on the AM/PM field.
    set_clock_mode(1'b1);
    queue_req(load_req(dtse_pkg::TGT_TIME, 31, 0, 1, 1, 1, 0));
    queue_req(press_req(dtse_pkg::BTN_DOWN));
    queue_req(press_req(dtse_pkg::BTN_ENTER));
    queue_req(press_req(dtse_pkg::BTN_DOWN));
    queue_req(press_req(dtse_pkg::BTN_ENTER));
    queue_req(press_req(dtse_pkg::BTN_UP));
    wait_idle();

    // Back to 24-hour with the cursor past the last field: up does nothing, enter commits.
    set_clock_mode(1'b0);
    queue_req(press_req(dtse_pkg::BTN_UP));
    queue_req(press_req(dtse_pkg::BTN_ENTER));
    wait_idle();

    // Random phases, alternating the mode; sessions left open carry across the
    // switch. The second phase holds the sink off, the last runs without idling.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_clock_mode(ph % 2 == 0);
      if (ph == NUM_PHASES - 1) steady_run = 1'b1;
      if (ph == 1) hold_off_asked++;
      queue_random_sessions(PHASE_REQS);
      wait_idle();
    end

    $display("run covered %0d requests (%0d loads), %0d results checked, %0d commits, %0d cancels",
             reqs_accepted, loads_accepted, results_checked, commits_seen, cancels_seen);
    $display("both clock modes, mode switch mid-session, out-of-range loads, %0d-cycle sink hold",
             HOLD_CYCLES);
    if (mismatch_count == 0 && editor_snapshots.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
